// ===== design/qcsv_pkg.sv =====
// Package for the quoted CSV parameter splitter.
// Holds the size constants, byte and status codes and the result record.
// No dependencies.
package qcsv_pkg;

  localparam int unsigned MAX_PARAM_LEN = 256;
  localparam int unsigned MAX_PARAMS    = 16;

  localparam int unsigned LEN_W   = $clog2(MAX_PARAM_LEN + 1);
  localparam int unsigned INDEX_W = $clog2(MAX_PARAMS);
  localparam int unsigned COUNT_W = $clog2(MAX_PARAMS + 1);
  localparam int unsigned CFG_W   = 5;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic CFG_MIN_PARAMS = 1'b0;
  localparam logic CFG_MAX_PARAMS = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_UNQUOTED = 2'd1,
    STATUS_TOO_FEW  = 2'd2,
    STATUS_TOO_MANY = 2'd3
  } status_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         data;
    logic [INDEX_W-1:0] param_index;
    logic [LEN_W-1:0]   param_length;
    logic               quoted;
    logic               too_long;
    logic               last;
    status_t            status;
    logic [COUNT_W-1:0] param_count;
  } result_t;

endpackage

// ===== design/quoted_csv_param_splitter.sv =====
// Quoted CSV parameter splitter top level.
// Depends on qcsv_pkg for constants, status codes and the result record.
//
// Usage: bytes of a parameter string enter on the input channel (in_valid,
// in_stall, char_in); a zero byte ends the string. Each accepted transaction
// yields at most one result transaction on the output channel (out_valid,
// out_stall and the field ports): a content byte, or an end-of-parameter
// record for a comma outside quotes or for the closing zero byte, which also
// carries the string status and parameter count. Quote bytes yield nothing.
// The result of an accepted byte is registered in the output register, or in
// the skid register while the output register is held. One byte is taken every
// cycle while in_stall is low; quote mode, length and index update per byte.
// The output register is backed by a one-entry skid register, so a byte is
// still taken while a result waits; in_stall rises only once the skid entry
// is full and falls when the receiver takes a result.
// The configuration port writes min_params (index 0) and max_params (index 1);
// the user must write it only while the block is idle; the block does not check.
// Reset clears the parse state and both output entries and sets min_params
// to 1 and max_params to 16.
module quoted_csv_param_splitter
  import qcsv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            char_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  kind,
  output logic [7:0]            data,
  output logic [INDEX_W-1:0]    param_index,
  output logic [LEN_W-1:0]      param_length,
  output logic                  quoted,
  output logic                  too_long,
  output logic                  last,
  output logic [1:0]            status,
  output logic [COUNT_W-1:0]    param_count
);

  logic [CFG_W-1:0]   min_params;
  logic [CFG_W-1:0]   max_params;

  logic               in_quote, in_quote_next;
  logic               quote_seen, quote_seen_next;
  logic [LEN_W-1:0]   cur_length, cur_length_next;
  logic [INDEX_W-1:0] cur_index, cur_index_next;
  logic               overflow_count, overflow_count_next;

  result_t            res;
  logic               res_valid;
  result_t            out_r;
  result_t            skid_r;
  logic               skid_valid;

  logic               in_fire;
  logic               out_fire;
  logic               long_flag;
  logic [COUNT_W-1:0] count;
  status_t            end_status;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  assign long_flag = (cur_length >= LEN_W'(MAX_PARAM_LEN));
  assign count     = COUNT_W'(cur_index) + COUNT_W'(1);

  always_comb begin
    if (in_quote) begin
      end_status = STATUS_UNQUOTED;
    end else if (count < COUNT_W'(min_params)) begin
      end_status = STATUS_TOO_FEW;
    end else if (overflow_count || (count > COUNT_W'(max_params))) begin
      end_status = STATUS_TOO_MANY;
    end else begin
      end_status = STATUS_OK;
    end
  end

  always_comb begin
    in_quote_next       = in_quote;
    quote_seen_next     = quote_seen;
    cur_length_next     = cur_length;
    cur_index_next      = cur_index;
    overflow_count_next = overflow_count;
    res                 = '0;
    res.param_index     = cur_index;
    res_valid           = 1'b0;
    if (char_in == CH_NUL) begin
      res_valid           = 1'b1;
      res.kind            = KIND_END;
      res.param_length    = cur_length;
      res.quoted          = quote_seen;
      res.too_long        = long_flag;
      res.last            = 1'b1;
      res.status          = end_status;
      res.param_count     = count;
      in_quote_next       = 1'b0;
      overflow_count_next = 1'b0;
      cur_index_next      = '0;
      quote_seen_next     = 1'b0;
      cur_length_next     = '0;
    end else if (char_in == CH_QUOTE) begin
      in_quote_next = !in_quote;
      if (in_quote) begin
        quote_seen_next = 1'b1;
      end
    end else if (char_in == CH_COMMA && !in_quote) begin
      res_valid        = 1'b1;
      res.kind         = KIND_END;
      res.param_length = cur_length;
      res.quoted       = quote_seen;
      res.too_long     = long_flag;
      if (cur_index != INDEX_W'(MAX_PARAMS - 1)) begin
        cur_index_next = cur_index + INDEX_W'(1);
      end else begin
        overflow_count_next = 1'b1;
      end
      quote_seen_next = 1'b0;
      cur_length_next = '0;
    end else begin
      res_valid = 1'b1;
      res.kind  = KIND_BYTE;
      res.data  = char_in;
      if (!long_flag) begin
        cur_length_next = cur_length + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_params <= CFG_W'(1);
      max_params <= CFG_W'(MAX_PARAMS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_PARAMS: min_params <= cfg_data;
        CFG_MAX_PARAMS: max_params <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quote       <= 1'b0;
      quote_seen     <= 1'b0;
      cur_length     <= '0;
      cur_index      <= '0;
      overflow_count <= 1'b0;
    end else if (in_fire) begin
      in_quote       <= in_quote_next;
      quote_seen     <= quote_seen_next;
      cur_length     <= cur_length_next;
      cur_index      <= cur_index_next;
      overflow_count <= overflow_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire && res_valid;
      end
    end else if (in_fire && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_r <= skid_r;
      end else begin
        out_r <= res;
      end
    end
    if (!skid_valid) begin
      skid_r <= res;
    end
  end

  assign kind         = out_r.kind;
  assign data         = out_r.data;
  assign param_index  = out_r.param_index;
  assign param_length = out_r.param_length;
  assign quoted       = out_r.quoted;
  assign too_long     = out_r.too_long;
  assign last         = out_r.last;
  assign status       = out_r.status;
  assign param_count  = out_r.param_count;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full while output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> !skid_valid)
    else $error("skid entry not moved when the receiver took a result");

  a_last_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (param_count != '0 && kind == KIND_END))
    else $error("final result without a parameter count");

  a_byte_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_BYTE) |-> (param_length == '0 && !last))
    else $error("content byte result carries end-of-parameter fields");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && char_in == CH_NUL) |=> (cur_index == '0 && !in_quote))
    else $error("parse state not cleared at end of string");

endmodule
